// ----- rtl/tpad_pkg.sv -----
// ----------------------------------------------------------------------------
// tpad_pkg
// Types and constants shared by the phase-angle dimmer modules.
// ----------------------------------------------------------------------------
package tpad_pkg;

    localparam int BRIGHT_INPUTS = 4;
    localparam int BRIGHT_W      = 7;
    localparam int GATE_W        = 4;
    localparam int CFG_ADDR_W    = 5;
    localparam int CFG_DATA_W    = 32;
    localparam int TIME_W        = 32;
    localparam int DELAY_W       = 14;
    localparam int PULSE_W       = 10;
    localparam int HOLDOFF_W     = 16;
    localparam int MASK_W        = 4;

    // brightness * (early - late) product, signed
    localparam int SPAN_W   = DELAY_W + 1;
    localparam int PROD_W   = BRIGHT_W + 1 + SPAN_W;
    localparam int MAG_W    = PROD_W - 2;
    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x < 2^21
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
    localparam int QPROD_W  = MAG_W + RECIP_W;
    localparam int QUOT_W   = QPROD_W - RECIP_SHIFT;
    localparam int SUM_W    = QUOT_W + 2;

    localparam logic [MASK_W-1:0]    RST_AC_MASK = 4'd0;
    localparam logic [HOLDOFF_W-1:0] RST_HOLDOFF = 16'd5000;
    localparam logic [PULSE_W-1:0]   RST_PULSE   = 10'd100;
    localparam logic [DELAY_W-1:0]   RST_LATE    = 14'd8000;
    localparam logic [DELAY_W-1:0]   RST_EARLY   = 14'd200;
    localparam logic [DELAY_W-1:0]   RST_MIN     = 14'd200;
    localparam logic [DELAY_W-1:0]   RST_MAX     = 14'd9900;

    typedef enum logic [2:0] {
        REG_AC_MASK = 3'd0,
        REG_HOLDOFF = 3'd1,
        REG_PULSE   = 3'd2,
        REG_LATE    = 3'd3,
        REG_EARLY   = 3'd4,
        REG_MIN     = 3'd5,
        REG_MAX     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [MASK_W-1:0]    ac_mask;
        logic [HOLDOFF_W-1:0] holdoff;
        logic [PULSE_W-1:0]   pulse;
        logic [DELAY_W-1:0]   late;
        logic [DELAY_W-1:0]   early;
        logic [DELAY_W-1:0]   min_d;
        logic [DELAY_W-1:0]   max_d;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               accepted;
        logic [TIME_W-1:0]  now;
        logic [PULSE_W-1:0] pulse;
    } tick_t;

endpackage

// ----- rtl/tpad_apb_regs.sv -----
// ----------------------------------------------------------------------------
// tpad_apb_regs
// APB configuration register file for the dimmer.
// ----------------------------------------------------------------------------
module tpad_apb_regs
    import tpad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t sel_w;
    logic     wr_w;

    assign sel_w  = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_w   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_w) begin
            case (sel_w)
                REG_AC_MASK: cfg_next.ac_mask = pwdata[MASK_W-1:0];
                REG_HOLDOFF: cfg_next.holdoff = pwdata[HOLDOFF_W-1:0];
                REG_PULSE:   cfg_next.pulse   = pwdata[PULSE_W-1:0];
                REG_LATE:    cfg_next.late    = pwdata[DELAY_W-1:0];
                REG_EARLY:   cfg_next.early   = pwdata[DELAY_W-1:0];
                REG_MIN:     cfg_next.min_d   = pwdata[DELAY_W-1:0];
                REG_MAX:     cfg_next.max_d   = pwdata[DELAY_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (sel_w)
            REG_AC_MASK: prdata = CFG_DATA_W'(cfg_reg.ac_mask);
            REG_HOLDOFF: prdata = CFG_DATA_W'(cfg_reg.holdoff);
            REG_PULSE:   prdata = CFG_DATA_W'(cfg_reg.pulse);
            REG_LATE:    prdata = CFG_DATA_W'(cfg_reg.late);
            REG_EARLY:   prdata = CFG_DATA_W'(cfg_reg.early);
            REG_MIN:     prdata = CFG_DATA_W'(cfg_reg.min_d);
            REG_MAX:     prdata = CFG_DATA_W'(cfg_reg.max_d);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ac_mask <= RST_AC_MASK;
            cfg_reg.holdoff <= RST_HOLDOFF;
            cfg_reg.pulse   <= RST_PULSE;
            cfg_reg.late    <= RST_LATE;
            cfg_reg.early   <= RST_EARLY;
            cfg_reg.min_d   <= RST_MIN;
            cfg_reg.max_d   <= RST_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/tpad_delay.sv -----
// ----------------------------------------------------------------------------
// tpad_delay
// Per-lane firing delay pipeline: late + trunc(b*(early-late)/100), clamped.
// ----------------------------------------------------------------------------
module tpad_delay
    import tpad_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [BRIGHT_W-1:0] brightness,
    input  cfg_t                cfg,
    output logic [DELAY_W-1:0]  delay,
    output logic                nonzero
);

    logic signed [BRIGHT_W:0]   b_w;
    logic signed [SPAN_W-1:0]   span_w;
    logic signed [PROD_W-1:0]   prod_w;
    logic signed [PROD_W-1:0]   p1_reg;
    logic                       nz1_reg;
    logic [MAG_W-1:0]           mag_w;
    logic [QPROD_W-1:0]         qp2_reg;
    logic                       neg2_reg;
    logic                       nz2_reg;
    logic [QUOT_W-1:0]          quot_w;
    logic signed [SUM_W-1:0]    sq_w;
    logic signed [SUM_W-1:0]    d_w;
    logic signed [SUM_W-1:0]    lo_w;
    logic signed [SUM_W-1:0]    hi_w;
    logic [DELAY_W-1:0]         clamp_w;
    logic [DELAY_W-1:0]         delay_reg;
    logic                       nz3_reg;

    assign b_w    = $signed({1'b0, brightness});
    assign span_w = $signed({1'b0, cfg.early}) - $signed({1'b0, cfg.late});
    assign prod_w = b_w * span_w;

    assign mag_w = p1_reg[PROD_W-1] ? MAG_W'(-p1_reg) : p1_reg[MAG_W-1:0];

    // stage 3: rescale, sign, offset and clamp
    assign quot_w = qp2_reg[QPROD_W-1:RECIP_SHIFT];
    assign sq_w   = neg2_reg ? -$signed({2'b00, quot_w}) : $signed({2'b00, quot_w});
    assign d_w    = $signed(SUM_W'(cfg.late)) + sq_w;
    assign lo_w   = $signed(SUM_W'(cfg.min_d));
    assign hi_w   = $signed(SUM_W'(cfg.max_d));

    always_comb begin
        if (d_w < lo_w) begin
            clamp_w = cfg.min_d;
        end else if (d_w > hi_w) begin
            clamp_w = cfg.max_d;
        end else begin
            clamp_w = d_w[DELAY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= prod_w;
            nz1_reg   <= (brightness != '0);
            qp2_reg   <= mag_w * RECIP_100;
            neg2_reg  <= p1_reg[PROD_W-1];
            nz2_reg   <= nz1_reg;
            delay_reg <= clamp_w;
            nz3_reg   <= nz2_reg;
        end
    end

    assign delay   = delay_reg;
    assign nonzero = nz3_reg;

endmodule

// ----- rtl/tpad_chan.sv -----
// ----------------------------------------------------------------------------
// tpad_chan
// Per-lane triac channel state: fire scheduling and gate pulse timing.
// ----------------------------------------------------------------------------
module tpad_chan
    import tpad_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  tick_t              tick,
    input  logic               enable,
    input  logic [DELAY_W-1:0] delay,
    input  logic               nonzero,
    output logic               active
);

    logic              pend_reg;
    logic              pend_next;
    logic              act_reg;
    logic              act_next;
    logic [TIME_W-1:0] fire_reg;
    logic [TIME_W-1:0] fire_next;
    logic [TIME_W-1:0] end_reg;
    logic [TIME_W-1:0] end_next;

    logic              pend_a;
    logic              act_a;
    logic [TIME_W-1:0] fire_a;
    logic [TIME_W-1:0] end_a;
    logic [TIME_W-1:0] fire_diff_w;
    logic [TIME_W-1:0] end_diff_w;
    logic              reach_fire_w;
    logic              start_w;
    logic              stop_w;

    assign fire_diff_w = tick.now - fire_reg;
    assign end_diff_w  = tick.now - end_reg;

    always_comb begin
        if (tick.accepted) begin
            pend_a = nonzero;
            fire_a = nonzero ? tick.now + TIME_W'(delay) : '0;
            act_a  = 1'b0;
            end_a  = '0;
            // new target is now + delay, reached only for a zero delay
            reach_fire_w = (delay == '0);
        end else begin
            pend_a = pend_reg;
            fire_a = fire_reg;
            act_a  = act_reg;
            end_a  = end_reg;
            reach_fire_w = ~fire_diff_w[TIME_W-1];
        end
        start_w = pend_a & ~act_a & reach_fire_w;
        stop_w  = act_a & ~end_diff_w[TIME_W-1];

        pend_next = pend_a;
        fire_next = fire_a;
        act_next  = act_a;
        end_next  = end_a;
        if (start_w) begin
            act_next  = 1'b1;
            end_next  = tick.now + TIME_W'(tick.pulse);
            pend_next = 1'b0;
            fire_next = '0;
        end else if (stop_w) begin
            act_next = 1'b0;
            end_next = '0;
        end
    end

    assign active = act_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            act_reg  <= 1'b0;
            fire_reg <= '0;
            end_reg  <= '0;
        end else if (tick.valid && enable) begin
            pend_reg <= pend_next;
            act_reg  <= act_next;
            fire_reg <= fire_next;
            end_reg  <= end_next;
        end
    end

endmodule

// ----- rtl/triac_phase_angle_dimmer_unit.sv -----
// ----------------------------------------------------------------------------
// triac_phase_angle_dimmer_unit
// Phase-angle triac dimmer: zero-cross holdoff filter and per-channel gates.
// A word moves from v1 through v2 and v3 to the output. Throughput: one word
// per cycle unless the output stalls; the delay lanes are a 3-stage pipeline
// (multiply, reciprocal multiply, clamp) feeding the channel state stage.
// Reset: synchronous, clears time, zero-cross history, channel flags and
// loads the register defaults.
// ----------------------------------------------------------------------------
module triac_phase_angle_dimmer_unit
    import tpad_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_zc_edge,
    input  logic [BRIGHT_W-1:0]   s_brightness_0,
    input  logic [BRIGHT_W-1:0]   s_brightness_1,
    input  logic [BRIGHT_W-1:0]   s_brightness_2,
    input  logic [BRIGHT_W-1:0]   s_brightness_3,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [GATE_W-1:0]     m_gate_mask,
    output logic                  m_zc_accepted,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LANES = (NUM_CHANNELS < BRIGHT_INPUTS) ? NUM_CHANNELS : BRIGHT_INPUTS;

    cfg_t              cfg;
    tick_t             tick_w;
    logic              adv_w;
    logic              v1_reg, v2_reg, v3_reg;
    logic              zc1_reg, zc2_reg, zc3_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] since_w;
    logic              acc_w;
    logic              m_valid_reg;
    logic [GATE_W-1:0] m_gate_reg;
    logic              m_zc_reg;
    logic [GATE_W-1:0] gates_w;
    logic [BRIGHT_W-1:0] bright_w [BRIGHT_INPUTS];

    assign bright_w[0] = s_brightness_0;
    assign bright_w[1] = s_brightness_1;
    assign bright_w[2] = s_brightness_2;
    assign bright_w[3] = s_brightness_3;

    tpad_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign adv_w   = ~m_valid_reg | m_ready;
    assign s_ready = adv_w;

    assign since_w = time_reg - last_reg;
    assign acc_w   = zc3_reg & (since_w > TIME_W'(cfg.holdoff));

    assign tick_w.valid    = adv_w & v3_reg;
    assign tick_w.accepted = acc_w;
    assign tick_w.now      = time_reg;
    assign tick_w.pulse    = cfg.pulse;

    genvar gi;
    generate
        for (gi = 0; gi < GATE_W; gi++) begin : g_lane
            if (gi < LANES) begin : g_on
                logic [DELAY_W-1:0] delay_w;
                logic               nz_w;
                logic               act_w;

                tpad_delay u_delay (
                    .aclk       (aclk),
                    .en         (adv_w),
                    .brightness (bright_w[gi]),
                    .cfg        (cfg),
                    .delay      (delay_w),
                    .nonzero    (nz_w)
                );

                tpad_chan u_chan (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .tick    (tick_w),
                    .enable  (cfg.ac_mask[gi]),
                    .delay   (delay_w),
                    .nonzero (nz_w),
                    .active  (act_w)
                );

                assign gates_w[gi] = act_w & cfg.ac_mask[gi];
            end else begin : g_off
                assign gates_w[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            time_reg    <= '0;
            last_reg    <= '0;
        end else if (adv_w) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
            if (v3_reg) begin
                time_reg <= time_reg + 1'b1;
                if (acc_w) begin
                    last_reg <= time_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_w) begin
            zc1_reg    <= s_zc_edge;
            zc2_reg    <= zc1_reg;
            zc3_reg    <= zc2_reg;
            m_gate_reg <= gates_w;
            m_zc_reg   <= acc_w;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_gate_mask   = m_gate_reg;
    assign m_zc_accepted = m_zc_reg;

    // time advances by one for every word that leaves the channel stage
    a_time_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(adv_w && v3_reg)) |-> time_reg == $past(time_reg) + 1'b1)
        else $error("time counter did not advance with a word");

    // an accepted zero cross records the tick it belongs to
    a_zc_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_zc_reg) |-> last_reg == time_reg - 1'b1)
        else $error("accepted zero cross not recorded");

    // a zero cross is only accepted for a word that carried an edge
    a_zc_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(adv_w && v3_reg) && m_zc_reg) |-> $past(zc3_reg))
        else $error("zero cross accepted without an edge");

    // the held result stays put while the sink stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(m_valid_reg && !m_ready)) |->
        (m_valid_reg && $stable(m_gate_reg) && $stable(last_reg) && $stable(time_reg)))
        else $error("state moved during an output stall");

endmodule

// ----- sim/triac_phase_angle_dimmer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triac_phase_angle_dimmer_unit_test
// Self-checking bench for the phase-angle dimmer. A tick model in the
// scoreboard follows the zero-cross holdoff filter, delay mapping, clamps
// and gate pulses, and each output word is compared with the oldest
// predicted one. Directed ticks come first, then random half-cycle
// sequences over many register settings and both handshake sides stalling.
// ----------------------------------------------------------------------------
import tpad_pkg::*;

typedef struct packed {
    logic [GATE_W-1:0] gates;
    logic              zc_ok;
} gate_word_t;

class dimmer_scoreboard;
    localparam int FULL_SCALE = 100;
    localparam int MAX_SHOWN  = 40;

    logic [MASK_W-1:0]    ac_mask;
    logic [HOLDOFF_W-1:0] holdoff;
    logic [PULSE_W-1:0]   pulse_len;
    logic [DELAY_W-1:0]   late_d;
    logic [DELAY_W-1:0]   early_d;
    logic [DELAY_W-1:0]   min_d;
    logic [DELAY_W-1:0]   max_d;

    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] last_zc;
    logic [TIME_W-1:0] fire_at [GATE_W];
    bit                fire_wait [GATE_W];
    bit                gate_on [GATE_W];
    logic [TIME_W-1:0] gate_end [GATE_W];

    gate_word_t gate_words_due[$];
    int errors;
    int checked;
    int zc_seen;
    int gate_ticks;

    function new();
        ac_mask   = RST_AC_MASK;
        holdoff   = RST_HOLDOFF;
        pulse_len = RST_PULSE;
        late_d    = RST_LATE;
        early_d   = RST_EARLY;
        min_d     = RST_MIN;
        max_d     = RST_MAX;
        now_t     = '0;
        last_zc   = '0;
        for (int i = 0; i < GATE_W; i++) begin
            fire_at[i]   = '0;
            fire_wait[i] = 1'b0;
            gate_on[i]   = 1'b0;
            gate_end[i]  = '0;
        end
        errors     = 0;
        checked    = 0;
        zc_seen    = 0;
        gate_ticks = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
        case (r)
            REG_AC_MASK: ac_mask   = v[MASK_W-1:0];
            REG_HOLDOFF: holdoff   = v[HOLDOFF_W-1:0];
            REG_PULSE:   pulse_len = v[PULSE_W-1:0];
            REG_LATE:    late_d    = v[DELAY_W-1:0];
            REG_EARLY:   early_d   = v[DELAY_W-1:0];
            REG_MIN:     min_d     = v[DELAY_W-1:0];
            REG_MAX:     max_d     = v[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    // late + (b * (early - late)) / 100, truncated toward zero, then clamped
    function logic [TIME_W-1:0] firing_delay(logic [BRIGHT_W-1:0] b);
        int late_i;
        int span;
        int d;
        late_i = int'(late_d);
        span   = int'(early_d) - late_i;
        d      = late_i + (int'(b) * span) / FULL_SCALE;
        if (d < int'(min_d))
            d = int'(min_d);
        else if (d > int'(max_d))
            d = int'(max_d);
        return d;
    endfunction

    function bit reached(logic [TIME_W-1:0] now_v, logic [TIME_W-1:0] target);
        logic [TIME_W-1:0] diff;
        diff = now_v - target;
        return !diff[TIME_W-1];
    endfunction

    function void predict_tick(logic zc,
                               logic [BRIGHT_INPUTS-1:0][BRIGHT_W-1:0] lv);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] since;
        bit                acc;
        bit                was;
        gate_word_t        w;
        t       = now_t;
        since   = t - last_zc;
        acc     = 1'b0;
        w.gates = '0;
        if (zc && since > holdoff) begin
            acc     = 1'b1;
            last_zc = t;
        end
        for (int i = 0; i < BRIGHT_INPUTS; i++) begin
            if (ac_mask[i]) begin
                if (acc) begin
                    if (lv[i] == '0) begin
                        fire_at[i]   = '0;
                        fire_wait[i] = 1'b0;
                    end else begin
                        fire_at[i]   = t + firing_delay(lv[i]);
                        fire_wait[i] = 1'b1;
                    end
                    gate_on[i]  = 1'b0;
                    gate_end[i] = '0;
                end
                was = gate_on[i];
                if (fire_wait[i] && !was && reached(t, fire_at[i])) begin
                    gate_on[i]   = 1'b1;
                    gate_end[i]  = t + pulse_len;
                    fire_wait[i] = 1'b0;
                    fire_at[i]   = '0;
                end
                if (was && reached(t, gate_end[i])) begin
                    gate_on[i]  = 1'b0;
                    gate_end[i] = '0;
                end
                w.gates[i] = gate_on[i];
            end
        end
        w.zc_ok = acc;
        now_t   = t + 1;
        gate_words_due.push_back(w);
    endfunction

    function void check_gate_word(logic [GATE_W-1:0] g, logic z);
        gate_word_t w;
        if (gate_words_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, gate_mask %h zc_accepted %b", $time, g, z);
            return;
        end
        w = gate_words_due.pop_front();
        checked++;
        if (w.zc_ok)
            zc_seen++;
        if (w.gates != '0)
            gate_ticks++;
        if (g !== w.gates) begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: gate_mask expected %h actual %h", $time, w.gates, g);
        end
        if (z !== w.zc_ok) begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: zc_accepted expected %b actual %b", $time, w.zc_ok, z);
        end
    endfunction
endclass

module triac_phase_angle_dimmer_unit_test;
    import tpad_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int WORDS_PER_SETTING = 125;
    localparam int NUM_SETTINGS      = 12;
    localparam int DIRECTED_WORDS    = 22;
    localparam int NUM_REGS          = REG_MAX + 1;
    localparam int DRAIN_CYCLES      = 20;

    typedef enum int {
        SET_RANDOM,
        SET_LOW,
        SET_HIGH,
        SET_STEEP,
        SET_CROSSED
    } setting_kind_t;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    wire                   s_ready;
    logic                  s_zc_edge      = 1'b0;
    logic [BRIGHT_W-1:0]   s_brightness_0 = '0;
    logic [BRIGHT_W-1:0]   s_brightness_1 = '0;
    logic [BRIGHT_W-1:0]   s_brightness_2 = '0;
    logic [BRIGHT_W-1:0]   s_brightness_3 = '0;
    wire                   m_valid;
    logic                  m_ready        = 1'b0;
    wire  [GATE_W-1:0]     m_gate_mask;
    wire                   m_zc_accepted;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr          = '0;
    logic [CFG_DATA_W-1:0] pwdata         = '0;
    wire  [CFG_DATA_W-1:0] prdata;
    wire                   pready;

    dimmer_scoreboard      board;
    logic [CFG_DATA_W-1:0] setting [NUM_REGS];
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    stall_cycles  = 0;
    int                    words_sent    = 0;

    always #1 aclk = ~aclk;

    triac_phase_angle_dimmer_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_zc_edge      (s_zc_edge),
        .s_brightness_0 (s_brightness_0),
        .s_brightness_1 (s_brightness_1),
        .s_brightness_2 (s_brightness_2),
        .s_brightness_3 (s_brightness_3),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gate_mask    (m_gate_mask),
        .m_zc_accepted  (m_zc_accepted),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            board.check_gate_word(m_gate_mask, m_zc_accepted);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** triac_phase_angle_dimmer_unit: FAILED **");
        $finish;
    end

    function automatic logic [BRIGHT_W-1:0] random_level();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return '0;
        else if (r < 24)
            return BRIGHT_W'($urandom_range(127, 101));
        return BRIGHT_W'($urandom_range(100, 1));
    endfunction

    function automatic void fill_setting(setting_kind_t kind);
        setting[REG_AC_MASK] = $urandom_range(1) ? 15 : $urandom_range(15);
        setting[REG_HOLDOFF] = $urandom_range(30);
        setting[REG_PULSE]   = $urandom_range(12);
        setting[REG_LATE]    = $urandom_range(50);
        setting[REG_EARLY]   = $urandom_range(50);
        setting[REG_MIN]     = $urandom_range(30);
        setting[REG_MAX]     = $urandom_range(60);
        case (kind)
            SET_LOW: begin
                setting[REG_AC_MASK] = 15;
                setting[REG_HOLDOFF] = 0;
                setting[REG_PULSE]   = 0;
                setting[REG_LATE]    = 0;
                setting[REG_EARLY]   = 0;
                setting[REG_MIN]     = 0;
                setting[REG_MAX]     = 0;
            end
            SET_HIGH: begin
                setting[REG_AC_MASK] = 15;
                setting[REG_HOLDOFF] = 65535;
                setting[REG_PULSE]   = 1023;
                setting[REG_LATE]    = 16383;
                setting[REG_EARLY]   = 16383;
                setting[REG_MIN]     = 16383;
                setting[REG_MAX]     = 16383;
            end
            SET_STEEP: begin
                setting[REG_PULSE] = 3;
                setting[REG_LATE]  = 16383;
                setting[REG_EARLY] = 0;
                setting[REG_MIN]   = 5;
                setting[REG_MAX]   = 20;
            end
            SET_CROSSED: begin
                setting[REG_HOLDOFF] = 10;
                setting[REG_PULSE]   = 2;
                setting[REG_LATE]    = 40;
                setting[REG_EARLY]   = 0;
                setting[REG_MIN]     = 30;
                setting[REG_MAX]     = 10;
            end
            default: ;
        endcase
    endfunction

    task automatic load_setting();
        for (int i = 0; i < NUM_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {cfg_reg_t'(i), 2'b00};
            pwdata  <= setting[i];
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            board.write_reg(cfg_reg_t'(i), setting[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(input logic zc,
                             input logic [BRIGHT_INPUTS-1:0][BRIGHT_W-1:0] lv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_zc_edge      <= zc;
        s_brightness_0 <= lv[0];
        s_brightness_1 <= lv[1];
        s_brightness_2 <= lv[2];
        s_brightness_3 <= lv[3];
        do @(posedge aclk); while (!s_ready);
        board.predict_tick(zc, lv);
        words_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.gate_words_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic                                  zc;
        logic [BRIGHT_INPUTS-1:0][BRIGHT_W-1:0] levels;
        setting_kind_t                         kind;
        int                                    zc_countdown;

        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short delays so pulses show up within a few ticks
        setting[REG_AC_MASK] = 15;
        setting[REG_HOLDOFF] = 3;
        setting[REG_PULSE]   = 2;
        setting[REG_LATE]    = 10;
        setting[REG_EARLY]   = 0;
        setting[REG_MIN]     = 1;
        setting[REG_MAX]     = 12;
        load_setting();

        // edges right after reset fall inside the holdoff; tick 18 is spurious
        for (int k = 0; k < DIRECTED_WORDS; k++) begin
            for (int i = 0; i < BRIGHT_INPUTS; i++) begin
                case ((k + 3 * i) % 8)
                    0: levels[i] = 0;
                    1: levels[i] = 1;
                    2: levels[i] = 100;
                    3: levels[i] = 127;
                    4: levels[i] = 50;
                    5: levels[i] = 99;
                    6: levels[i] = 64;
                    default: levels[i] = 63;
                endcase
            end
            zc = (k < 5) || (k == 8) || (k == 12) || (k == 17) || (k == 18);
            send_word(zc, levels);
        end
        wait_for_results();

        for (int n = 0; n < NUM_SETTINGS; n++) begin
            send_idle_pct = (n < 4) ? 14 : (n < 8) ? 72 : 0;
            recv_idle_pct = (n < 4) ? 72 : (n < 8) ? 14 : 0;
            case (n)
                0, 11: kind = SET_LOW;
                4:     kind = SET_HIGH;
                2, 9:  kind = SET_STEEP;
                6, 10: kind = SET_CROSSED;
                default: kind = SET_RANDOM;
            endcase
            fill_setting(kind);
            load_setting();
            zc_countdown = 0;
            for (int w = 0; w < WORDS_PER_SETTING; w++) begin
                zc = 1'b0;
                if (zc_countdown == 0) begin
                    zc           = 1'b1;
                    zc_countdown = int'(setting[REG_HOLDOFF]) + $urandom_range(8, 1);
                    for (int i = 0; i < BRIGHT_INPUTS; i++)
                        levels[i] = random_level();
                end else begin
                    zc_countdown--;
                    if ($urandom_range(99) < 6)
                        zc = 1'b1;
                end
                for (int i = 0; i < BRIGHT_INPUTS; i++)
                    if ($urandom_range(99) < 8)
                        levels[i] = random_level();
                send_word(zc, levels);
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d ticks over %0d register settings, %0d words checked",
                 words_sent, NUM_SETTINGS + 1, board.checked);
        $display("run: %0d zero crossings accepted, %0d ticks with a gate driven",
                 board.zc_seen, board.gate_ticks);
        if (board.errors == 0 && board.gate_words_due.size() == 0)
            $display("** triac_phase_angle_dimmer_unit: PASSED **");
        else
            $display("** triac_phase_angle_dimmer_unit: FAILED **");
        $finish;
    end

endmodule
